// ----- src/pip_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants
// Command codes, decoded operation format and queue geometry for the
// point-in-convex-polygon block.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // Raw command field codes
    localparam logic [1:0] CMD_NEW    = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_NEW,
        OP_APPEND,
        OP_QUERY
    } t_op_kind;

    typedef struct packed {
        t_op_kind                   kind;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_op;

    // Head of the operation queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

endpackage
`default_nettype wire

// ----- src/pip_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pip_front: request intake and classification
// Decodes each request into an operation, drops unused commands and holds
// the operations in a short queue for the back end.
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_cmd,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    output t_qhead                         o_head,
    input  wire logic                      i_pop
);

    t_op                 r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    logic     w_accept;
    logic     w_keep;
    t_op_kind w_kind;
    logic     w_push;
    logic     w_pop;

    always_comb begin
        w_keep = 1'b1;
        w_kind = OP_NEW;
        case (i_cmd)
            CMD_NEW:    w_kind = OP_NEW;
            CMD_APPEND: w_kind = OP_APPEND;
            CMD_QUERY:  w_kind = OP_QUERY;
            default:    w_keep = 1'b0;
        endcase
    end

    assign o_in_stall = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_push     = w_accept && w_keep;
    assign w_pop      = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{kind: w_kind, x: i_coord_x, y: i_coord_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (QUEUE_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QUEUE_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/pip_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pip_back: vertex store and edge sweep
// Executes queued operations: writes vertices into the store and, for a
// query, sweeps every edge through a cross-product pipeline.
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qhead i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output logic        o_inside_res,
    output logic        o_truncated
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(MAX_VERTICES + 2);
    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    logic [2*COORD_W-1:0] r_mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] r_rd_data;

    logic [CW-1:0]              r_count;
    logic                       r_ovf;
    logic signed [COORD_W-1:0]  r_px;
    logic signed [COORD_W-1:0]  r_py;
    logic [AW-1:0]              r_addr;
    logic [IW-1:0]              r_issue_left;
    logic                       r_first;
    logic                       r_s1_v;
    logic                       r_s1_first;
    logic                       r_s2_v;
    logic                       r_s2_first;
    logic                       r_s3_v;
    logic signed [DW-1:0]       r_dx;
    logic signed [DW-1:0]       r_dy;
    logic signed [DW-1:0]       r_pdx;
    logic signed [DW-1:0]       r_pdy;
    logic signed [PW-1:0]       r_p1;
    logic signed [PW-1:0]       r_p2;
    logic                       r_pos;
    logic                       r_neg;
    logic                       r_out_valid;
    logic                       r_out_inside;
    logic                       r_out_trunc;

    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic                 w_rd_en;
    logic [AW-1:0]        w_next_addr;
    logic [CW-1:0]        w_addr_inc;
    logic                 w_out_free;
    logic                 w_room;
    logic [PW:0]          w_cross;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;

    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_room     = (r_count < MAX_CNT);
    assign w_wr_en    = o_pop && ((i_head.op.kind == OP_NEW) ||
                                  ((i_head.op.kind == OP_APPEND) && w_room));
    assign w_wr_addr  = (i_head.op.kind == OP_NEW) ? '0 : r_count[AW-1:0];
    assign w_rd_en    = (r_state == S_RUN);
    assign w_addr_inc = CW'(r_addr) + CW'(1);
    // wrap back to vertex 0 to close the polygon
    assign w_next_addr = (w_addr_inc == r_count) ? '0 : w_addr_inc[AW-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_dx = $signed({r_rd_data[2*COORD_W-1], r_rd_data[2*COORD_W-1:COORD_W]})
                - $signed({r_px[COORD_W-1], r_px});
    assign w_dy = $signed({r_rd_data[COORD_W-1], r_rd_data[COORD_W-1:0]})
                - $signed({r_py[COORD_W-1], r_py});
    assign w_cross = {r_p1[PW-1], r_p1} - {r_p2[PW-1], r_p2};

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_truncated  = r_out_trunc;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= {i_head.op.x, i_head.op.y};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_dx <= w_dx;
            r_dy <= w_dy;
        end
        if (r_s2_v) begin
            r_pdx <= r_dx;
            r_pdy <= r_dy;
            r_p1  <= r_pdx * r_dy;
            r_p2  <= r_pdy * r_dx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_first      <= 1'b0;
            r_s1_v       <= 1'b0;
            r_s1_first   <= 1'b0;
            r_s2_v       <= 1'b0;
            r_s2_first   <= 1'b0;
            r_s3_v       <= 1'b0;
            r_pos        <= 1'b0;
            r_neg        <= 1'b0;
            r_addr       <= '0;
            r_issue_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // a result loaded in S_DONE takes the place of the one leaving
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            r_s1_v     <= w_rd_en;
            r_s1_first <= w_rd_en && r_first;
            r_s2_v     <= r_s1_v;
            r_s2_first <= r_s1_first;
            // the first vertex of a sweep opens no edge
            r_s3_v     <= r_s2_v && !r_s2_first;
            if (w_rd_en) begin
                r_first <= 1'b0;
            end

            if (r_s3_v) begin
                if (!w_cross[PW] && (w_cross != '0)) begin
                    r_pos <= 1'b1;
                end else if (w_cross[PW]) begin
                    r_neg <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.op.kind)
                            OP_NEW: begin
                                r_count <= CW'(1);
                                r_ovf   <= 1'b0;
                            end
                            OP_APPEND: begin
                                if (w_room) begin
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                r_px    <= i_head.op.x;
                                r_py    <= i_head.op.y;
                                r_pos   <= 1'b0;
                                r_neg   <= 1'b0;
                                r_addr  <= '0;
                                r_first <= 1'b1;
                                r_issue_left <= IW'(r_count) + IW'(1);
                                if (r_count == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RUN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN: begin
                    r_addr       <= w_next_addr;
                    r_issue_left <= r_issue_left - IW'(1);
                    if (r_issue_left == IW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_s2_v && !r_s3_v) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= !(r_pos && r_neg);
                        r_out_trunc  <= r_ovf;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("vertex count beyond capacity");

    a_run_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_issue_left != '0))
        else $error("edge sweep running with no reads left");

    a_pipe_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v || r_s2_v || r_s3_v) |-> ((r_state == S_RUN) || (r_state == S_DRAIN)))
        else $error("pipeline busy outside a query");

    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> (r_count == MAX_CNT))
        else $error("overflow flagged with room in store");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_inside)))
        else $error("held result overwritten");
`endif

endmodule
`default_nettype wire

// ----- src/point_in_convex_polygon.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_convex_polygon: convex polygon containment test
// Stores a polygon vertex by vertex and answers point queries by the signs
// of the edge cross products, boundary counted as inside.
//
//   Channel  Direction  Handshake                  Payload
//   in       to block   i_in_valid / o_in_stall    i_cmd, i_coord_x, i_coord_y
//   out      from block o_out_valid / i_out_stall  o_inside_res, o_truncated
//
// A vertex request is executed in the back end as it is popped; a query's
// length is set by the single read port of the vertex store
// that feeds one edge per cycle into the cross-product pipeline.
// A two-entry queue decouples intake from execution, so requests are taken
// while a query runs or while a result waits on a stalled output.
// Reset (synchronous, active low) empties the polygon and clears the flag.
// ----------------------------------------------------------------------------
module point_in_convex_polygon import pip_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_cmd,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_inside_res,
    output logic                           o_truncated
);

    t_qhead w_head;
    logic   w_pop;

    pip_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    pip_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_inside_res (o_inside_res),
        .o_truncated  (o_truncated)
    );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_in_convex_polygon
// Drives vertex and query requests through the valid/stall input channel.
// A directed table covers the empty, single-vertex, full-range and overflow
// cases. Random convex polygons with queries in and around them follow.
// A local polygon model predicts each query result that the directed table does
// not give, and the bench compares each output in order while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    import pip_pkg::*;

    localparam int          MAX_V        = 64;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int          ITEMS_TARGET = 800;
    localparam int          QUIET_AT     = 700;
    localparam int          PAUSE_AT     = 450;
    localparam int          HOLD_AT      = 250;
    localparam int          HOLD_CYCLES  = 500;
    localparam int          TAIL_CYCLES  = 150;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          NUM_ROWS     = 30;

    typedef struct packed {
        logic in_poly;
        logic trunc;
    } t_verdict;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [6:0]         rpt;
        logic               typed;
        t_verdict           verdict;
    } t_dir_row;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [1:0]         i_cmd        = CMD_NEW;
    logic signed [15:0] i_coord_x    = '0;
    logic signed [15:0] i_coord_y    = '0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_inside_res;
    logic               o_truncated;

    // polygon model
    logic signed [15:0] poly_x [MAX_V];
    logic signed [15:0] poly_y [MAX_V];
    int unsigned        poly_count   = 0;
    bit                 poly_dropped = 1'b0;

    t_verdict           pending_verdicts [$];
    t_dir_row           directed_rows [NUM_ROWS];

    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned inside_seen     = 0;
    int unsigned dropped_seen    = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    bit          quiet_tail      = 1'b0;
    bit          pause_req       = 1'b0;
    bit          pause_done      = 1'b0;
    bit          long_hold       = 1'b0;
    int unsigned gap_odds        = 4;

    point_in_convex_polygon #(
        .MAX_VERTICES(MAX_V)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_inside_res (o_inside_res),
        .o_truncated  (o_truncated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("FAIL point_in_convex_polygon");
            $finish;
        end
    end

    function automatic void note_mismatch(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Update the polygon with one request; return 1 when it yields a result.
    function automatic bit apply_to_polygon(input logic [1:0] cmd,
                                            input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            output t_verdict v);
        int unsigned pos_n, neg_n, i, j;
        longint      ax, ay, bx, by, c;
        v = '0;
        case (cmd)
            CMD_NEW: begin
                poly_x[0]    = x;
                poly_y[0]    = y;
                poly_count   = 1;
                poly_dropped = 1'b0;
                return 1'b0;
            end
            CMD_APPEND: begin
                if (poly_count < MAX_V) begin
                    poly_x[poly_count] = x;
                    poly_y[poly_count] = y;
                    poly_count++;
                end else begin
                    poly_dropped = 1'b1;
                end
                return 1'b0;
            end
            CMD_QUERY: begin
                pos_n = 0;
                neg_n = 0;
                for (i = 0; i < poly_count; i++) begin
                    j  = (i + 1 == poly_count) ? 0 : i + 1;
                    ax = longint'(poly_x[i]) - longint'(x);
                    ay = longint'(poly_y[i]) - longint'(y);
                    bx = longint'(poly_x[j]) - longint'(x);
                    by = longint'(poly_y[j]) - longint'(y);
                    c  = ax * by - ay * bx;
                    if (c > 0)
                        pos_n++;
                    else if (c < 0)
                        neg_n++;
                end
                v.in_poly = (pos_n == 0) || (neg_n == 0);
                v.trunc   = poly_dropped;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic offer_request(logic [1:0] cmd, logic signed [15:0] x,
                                 logic signed [15:0] y, bit typed,
                                 t_verdict typed_v);
        t_verdict v;
        int       gap;
        @(negedge i_clk);
        gap = 0;
        if (!quiet_tail && !long_hold && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
            gap = $urandom_range(1, 16);
        if (pause_req && gap == 0)
            gap = 1;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            if (pause_req) begin
                while (pending_verdicts.size() != 0)
                    @(negedge i_clk);
                pause_req = 1'b0;
            end
        end
        i_cmd      <= cmd;
        i_coord_x  <= x;
        i_coord_y  <= y;
        i_in_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        if (apply_to_polygon(cmd, x, y, v))
            pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : v);
        if (cmd != CMD_UNUSED)
            requests_sent++;
    endtask

    // One convex polygon from points on a circle, then queries around it.
    task automatic run_polygon_round();
        int                 n, nq, cx, cy, span, k, pick, sel;
        real                rad, base, step, ang;
        bit                 cw;
        logic signed [15:0] vx [72];
        logic signed [15:0] vy [72];
        logic signed [15:0] qx, qy;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            n = $urandom_range(60, 70);
        else if (sel < 3)
            n = $urandom_range(1, 2);
        else
            n = $urandom_range(3, 8);
        cx   = int'($urandom_range(0, 65535)) - 32768;
        cy   = int'($urandom_range(0, 65535)) - 32768;
        rad  = real'($urandom_range(1, 1 << $urandom_range(1, 15)));
        base = real'($urandom_range(0, 359)) * 3.14159265 / 180.0;
        step = 2.0 * 3.14159265 / real'(n);
        cw   = $urandom_range(0, 1);
        for (k = 0; k < n; k++) begin
            // jitter stays under half a step so the vertex order holds
            ang = step * (real'(k) + real'($urandom_range(0, 800)) / 1000.0 - 0.4);
            ang = cw ? base - ang : base + ang;
            vx[k] = clamp16(cx + int'(rad * $cos(ang)));
            vy[k] = clamp16(cy + int'(rad * $sin(ang)));
            offer_request(k == 0 ? CMD_NEW : CMD_APPEND, vx[k], vy[k], 1'b0, '0);
            if ($urandom_range(0, 11) == 0)
                offer_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                              1'b0, '0);
        end
        nq   = $urandom_range(1, 5);
        span = int'(rad * 1.5) + 1;
        for (k = 0; k < nq; k++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                sel = $urandom_range(0, n - 1);
                qx  = vx[sel];
                qy  = vy[sel];
            end else if (pick == 1) begin
                qx = 16'($urandom);
                qy = 16'($urandom);
            end else begin
                qx = clamp16(cx + int'($urandom_range(0, 2 * span)) - span);
                qy = clamp16(cy + int'($urandom_range(0, 2 * span)) - span);
            end
            offer_request(CMD_QUERY, qx, qy, 1'b0, '0);
        end
    endtask

    // receiver: random stall bursts, one long hold, none in the tail
    int unsigned stall_left = 0;
    bit          stall_level = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!hold_done && requests_sent >= HOLD_AT) begin
            hold_done   = 1'b1;
            hold_left   = HOLD_CYCLES;
            long_hold   = 1'b1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            hold_left = 0;
            long_hold = 1'b0;
            if (quiet_tail) begin
                i_out_stall <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_level = ($urandom_range(0, 2) == 0);
                    if (!stall_level && $urandom_range(0, 7) == 0)
                        stall_left = 60;
                    else
                        stall_left = $urandom_range(1, 16);
                end
                stall_left--;
                i_out_stall <= stall_level;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                note_mismatch($sformatf("unexpected result inside=%0b truncated=%0b",
                                        o_inside_res, o_truncated));
            end else begin
                exp_v = pending_verdicts.pop_front();
                results_checked++;
                if (exp_v.in_poly)
                    inside_seen++;
                if (exp_v.trunc)
                    dropped_seen++;
                if (o_inside_res !== exp_v.in_poly)
                    note_mismatch($sformatf("result %0d inside: expected %0b got %0b",
                                            results_checked, exp_v.in_poly, o_inside_res));
                if (o_truncated !== exp_v.trunc)
                    note_mismatch($sformatf("result %0d truncated: expected %0b got %0b",
                                            results_checked, exp_v.trunc, o_truncated));
            end
        end
    end

    initial begin
        int r, k;
        directed_rows = '{
            // empty polygon reports inside
            '{CMD_QUERY,  16'sd0,      16'sd0,      7'd1,  1'b1, '{1'b1, 1'b0}},
            '{CMD_QUERY,  -16'sd32768, 16'sd32767,  7'd1,  1'b1, '{1'b1, 1'b0}},
            // single vertex, then a two-vertex segment
            '{CMD_NEW,    16'sd5,      -16'sd7,     7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd1000,   16'sd1000,   7'd1,  1'b1, '{1'b1, 1'b0}},
            '{CMD_APPEND, -16'sd32768, 16'sd32767,  7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd0,      16'sd0,      7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd32767,  -16'sd32768, 7'd1,  1'b0, '{1'b0, 1'b0}},
            // full-range square
            '{CMD_NEW,    -16'sd32768, -16'sd32768, 7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, 16'sd32767,  -16'sd32768, 7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, 16'sd32767,  16'sd32767,  7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, -16'sd32768, 16'sd32767,  7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd0,      16'sd0,      7'd1,  1'b1, '{1'b1, 1'b0}},
            '{CMD_QUERY,  16'sd32767,  16'sd32767,  7'd1,  1'b1, '{1'b1, 1'b0}},
            '{CMD_QUERY,  -16'sd1,     -16'sd32768, 7'd1,  1'b1, '{1'b1, 1'b0}},
            '{CMD_UNUSED, 16'sd123,    -16'sd456,   7'd1,  1'b0, '{1'b0, 1'b0}},
            // full-range triangle
            '{CMD_NEW,    -16'sd32768, -16'sd32768, 7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, 16'sd32767,  -16'sd32768, 7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, -16'sd32768, 16'sd32767,  7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd32767,  16'sd32767,  7'd1,  1'b1, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd0,      16'sd0,      7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  -16'sd32768, -16'sd32768, 7'd1,  1'b1, '{1'b1, 1'b0}},
            // overfill the store by one vertex
            '{CMD_NEW,    -16'sd100,   -16'sd100,   7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, 16'sd100,    -16'sd100,   7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_APPEND, 16'sd100,    16'sd100,    7'd63, 1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd0,      16'sd0,      7'd1,  1'b1, '{1'b1, 1'b1}},
            '{CMD_QUERY,  16'sd200,    16'sd0,      7'd1,  1'b1, '{1'b0, 1'b1}},
            '{CMD_APPEND, 16'sd1,      16'sd1,      7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  -16'sd32768, 16'sd32767,  7'd1,  1'b0, '{1'b0, 1'b0}},
            // new polygon clears the drop flag
            '{CMD_NEW,    16'sd0,      16'sd0,      7'd1,  1'b0, '{1'b0, 1'b0}},
            '{CMD_QUERY,  16'sd0,      16'sd0,      7'd1,  1'b1, '{1'b1, 1'b0}}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++)
            for (k = 0; k < directed_rows[r].rpt; k++)
                offer_request(directed_rows[r].cmd, directed_rows[r].x, directed_rows[r].y,
                              directed_rows[r].typed, directed_rows[r].verdict);

        while (requests_sent < ITEMS_TARGET) begin
            if (requests_sent % 64 < 8)
                gap_odds = $urandom_range(0, 2) * 3;
            // hold the sender once until every result is back
            if (!pause_done && requests_sent >= PAUSE_AT) begin
                pause_req  = 1'b1;
                pause_done = 1'b1;
            end
            quiet_tail = (requests_sent >= QUIET_AT);
            run_polygon_round();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d query results checked", requests_sent,
                 results_checked);
        $display("%0d results inside, %0d with vertices dropped, %0d mismatches",
                 inside_seen, dropped_seen, error_count);
        if (error_count == 0)
            $display("PASS point_in_convex_polygon");
        else
            $display("FAIL point_in_convex_polygon");
        $finish;
    end

endmodule
